/* rtl/code39_reflectance_decoder_unit_macros.svh */
// Assertion macros shared by the Code 39 decoder checker.
`ifndef CODE39_REFLECTANCE_DECODER_UNIT_MACROS_SVH
`define CODE39_REFLECTANCE_DECODER_UNIT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define C39_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks a property on every clock edge, including reset cycles.
`define C39_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/c39rd_pkg.sv */
// Types, constants and the symbol table for the Code 39 reflectance decoder.
package c39rd_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int TIME_BITS     = 32;
  localparam int THRESH_BITS   = 12;
  localparam int GAP_BITS      = 32;
  localparam int CHAR_BITS     = 8;
  localparam int ELEMENTS      = 9;
  localparam int TABLE_SIZE    = 40;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd2200;
  localparam logic [GAP_BITS-1:0]    GAP_RESET    = 32'd500000;
  localparam logic [CHAR_BITS-1:0]   INVALID_CHAR = 8'd63;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BLACK_THRESHOLD = 1'b0,
    REG_END_GAP         = 1'b1
  } cfg_reg_t;

  typedef logic [ELEMENTS-1:0]  sym_mask_t;
  typedef logic [CHAR_BITS-1:0] sym_char_t;

  localparam sym_mask_t SYM_MASKS [TABLE_SIZE] = '{
    9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
    9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
    9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
    9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0, 9'h085, 9'h184, 9'h0C4, 9'h094
  };

  localparam sym_char_t SYM_CHARS [TABLE_SIZE] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
    8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h2D, 8'h2E, 8'h20, 8'h2A
  };

endpackage

/* rtl/code39_reflectance_decoder_unit.sv */
// Code 39 reflectance decoder: thresholds timestamped reflectance samples into
// bars and spaces, measures the nine elements of a symbol and decodes it.
// One sample request is taken every clock cycle while in_stall is low. A result
// request passes through a snapshot register, a minimum-width register and the
// classify-and-match output register after the sample that closes the ninth
// element or ends a symbol on a long white gap. in_stall rises only while all
// three result stages are full and the output is stalled. Configuration writes
// take effect on the next sample.
module code39_reflectance_decoder_unit #(
  parameter int WIDTH_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [c39rd_pkg::SAMPLE_BITS-1:0]    in_sample,
  input  logic [c39rd_pkg::TIME_BITS-1:0]      in_time_us,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [c39rd_pkg::CHAR_BITS-1:0]      out_char_code,
  output logic                                 out_valid_res,
  output logic                                 out_reversed,
  input  logic                                 cfg_wr_en,
  input  logic [c39rd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [c39rd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import c39rd_pkg::*;

  localparam int STORE     = ELEMENTS - 1;
  localparam int IDX_BITS  = $clog2(STORE);
  localparam int CNT_BITS  = $clog2(ELEMENTS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ELEMENTS - 1);
  localparam logic [63:0] WMAX64 = (64'd1 << WIDTH_BITS) - 64'd1;
  localparam logic [TIME_BITS-1:0] WMAX = WMAX64[TIME_BITS-1:0];

  logic [THRESH_BITS-1:0] thr_r;
  logic [GAP_BITS-1:0]    gap_r;

  logic                   active_r, active_nxt;
  logic                   last_black_r, last_black_nxt;
  logic [TIME_BITS-1:0]   edge_r, edge_nxt;
  logic [CNT_BITS-1:0]    count_r, count_nxt;
  logic [WIDTH_BITS-1:0]  wid_r [STORE];

  logic                   snap_v_r;
  logic                   snap_gap_r;
  logic [WIDTH_BITS-1:0]  snap_w_r [ELEMENTS];

  logic                   d_v_r;
  logic                   d_gap_r;
  logic [WIDTH_BITS-1:0]  d_w_r [ELEMENTS];
  logic [WIDTH_BITS-1:0]  d_min_r;

  logic                   out_v_r;
  logic [CHAR_BITS-1:0]   out_char_r, out_char_nxt;
  logic                   out_vres_r, out_vres_nxt;
  logic                   out_rev_r, out_rev_nxt;

  logic                   out_adv, d_adv, s_adv, accept;
  logic                   black;
  logic [TIME_BITS-1:0]   dur;
  logic [WIDTH_BITS-1:0]  dur_sat;
  logic                   emit, emit_gap, store;
  logic [WIDTH_BITS-1:0]  min_w;
  logic [WIDTH_BITS+1:0]  min3;
  logic [ELEMENTS-1:0]    fwd, rev;

  assign out_adv  = !out_v_r || !out_stall;
  assign d_adv    = !d_v_r || out_adv;
  assign s_adv    = !snap_v_r || d_adv;
  assign in_stall = !s_adv;
  assign accept   = in_valid && s_adv;

  assign black   = in_sample > thr_r;
  assign dur     = in_time_us - edge_r;
  assign dur_sat = (dur > WMAX) ? WMAX[WIDTH_BITS-1:0] : dur[WIDTH_BITS-1:0];

  always_comb begin
    active_nxt     = active_r;
    last_black_nxt = last_black_r;
    edge_nxt       = edge_r;
    count_nxt      = count_r;
    emit           = 1'b0;
    emit_gap       = 1'b0;
    store          = 1'b0;
    if (accept) begin
      if (!active_r) begin
        if (black) begin
          active_nxt     = 1'b1;
          count_nxt      = '0;
          last_black_nxt = 1'b1;
          edge_nxt       = in_time_us;
        end
      end else if (black != last_black_r) begin
        if (black && (dur > gap_r)) begin
          emit           = 1'b1;
          emit_gap       = 1'b1;
          active_nxt     = 1'b1;
          count_nxt      = '0;
          last_black_nxt = 1'b1;
          edge_nxt       = in_time_us;
        end else begin
          store          = 1'b1;
          last_black_nxt = black;
          edge_nxt       = in_time_us;
          if (count_r == CNT_LAST) begin
            emit       = 1'b1;
            count_nxt  = '0;
            active_nxt = 1'b0;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
    end
  end

  // The narrowest of the nine captured elements.
  always_comb begin
    min_w = snap_w_r[0];
    for (int i = 1; i < ELEMENTS; i++) begin
      if (snap_w_r[i] < min_w) begin
        min_w = snap_w_r[i];
      end
    end
  end

  // An element is wide when twice its width exceeds three times the minimum.
  assign min3 = {2'b00, d_min_r} + {1'b0, d_min_r, 1'b0};

  always_comb begin
    for (int i = 0; i < ELEMENTS; i++) begin
      fwd[ELEMENTS-1-i] = {1'b0, d_w_r[i], 1'b0} > min3;
      rev[i]            = {1'b0, d_w_r[i], 1'b0} > min3;
    end
  end

  // Walking the table from the end lets the lowest entry win, and a forward
  // match beats a reversed one at the same entry.
  always_comb begin
    out_char_nxt = INVALID_CHAR;
    out_vres_nxt = 1'b0;
    out_rev_nxt  = 1'b0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (rev == SYM_MASKS[i]) begin
        out_char_nxt = SYM_CHARS[i];
        out_vres_nxt = 1'b1;
        out_rev_nxt  = 1'b1;
      end
      if (fwd == SYM_MASKS[i]) begin
        out_char_nxt = SYM_CHARS[i];
        out_vres_nxt = 1'b1;
        out_rev_nxt  = 1'b0;
      end
    end
    if (d_gap_r) begin
      out_char_nxt = INVALID_CHAR;
      out_vres_nxt = 1'b0;
      out_rev_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= THRESH_RESET;
      gap_r        <= GAP_RESET;
      active_r     <= 1'b0;
      last_black_r <= 1'b0;
      count_r      <= '0;
      snap_v_r     <= 1'b0;
      d_v_r        <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_BLACK_THRESHOLD: thr_r <= cfg_wdata[THRESH_BITS-1:0];
          REG_END_GAP:         gap_r <= cfg_wdata[GAP_BITS-1:0];
          default:             thr_r <= thr_r;
        endcase
      end
      active_r     <= active_nxt;
      last_black_r <= last_black_nxt;
      count_r      <= count_nxt;
      if (s_adv) begin
        snap_v_r <= emit;
      end
      if (d_adv) begin
        d_v_r <= snap_v_r;
      end
      if (out_adv) begin
        out_v_r <= d_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    edge_r <= edge_nxt;
    if (store && (count_r != CNT_LAST)) begin
      wid_r[count_r[IDX_BITS-1:0]] <= dur_sat;
    end
    if (emit) begin
      snap_gap_r <= emit_gap;
      for (int i = 0; i < STORE; i++) begin
        snap_w_r[i] <= wid_r[i];
      end
      snap_w_r[STORE] <= dur_sat;
    end
    if (d_adv) begin
      d_gap_r <= snap_gap_r;
      d_min_r <= min_w;
      for (int i = 0; i < ELEMENTS; i++) begin
        d_w_r[i] <= snap_w_r[i];
      end
    end
    if (out_adv) begin
      out_char_r <= out_char_nxt;
      out_vres_r <= out_vres_nxt;
      out_rev_r  <= out_rev_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_char_code = out_char_r;
  assign out_valid_res = out_vres_r;
  assign out_reversed  = out_rev_r;

endmodule

/* rtl/c39rd_checker.sv */
// Port-level assertion checker for the Code 39 decoder, bound to the top level.
`include "code39_reflectance_decoder_unit_macros.svh"

module c39rd_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [c39rd_pkg::SAMPLE_BITS-1:0]    in_sample,
  input logic [c39rd_pkg::TIME_BITS-1:0]      in_time_us,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [c39rd_pkg::CHAR_BITS-1:0]      out_char_code,
  input logic                                 out_valid_res,
  input logic                                 out_reversed,
  input logic                                 cfg_wr_en,
  input logic [c39rd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input logic [c39rd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import c39rd_pkg::*;

  logic in_quiet;
  logic cfg_quiet;

  assign in_quiet  = !in_valid || (in_sample == in_sample) || (in_time_us == in_time_us);
  assign cfg_quiet = !cfg_wr_en || (cfg_index == cfg_index) || (cfg_wdata == cfg_wdata);

  `C39_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_char_code) && $stable(out_valid_res) && $stable(out_reversed)), "Stalled result request changed")

  `C39_ASSERT(a_invalid_form, clk, rst_n, (out_valid && !out_valid_res && in_quiet) |-> (!out_reversed && (out_char_code == INVALID_CHAR)), "Invalid result carries a character or direction")

  `C39_ASSERT(a_valid_char, clk, rst_n, (out_valid && out_valid_res && cfg_quiet) |-> (out_char_code != INVALID_CHAR), "Matched result carries the invalid character")

  `C39_ASSERT(a_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall), "Input stalled while the output is free")

  `C39_ASSERT_ALWAYS(a_reset_idle, clk, (!rst_n) |=> (!out_valid && !in_stall), "Result pending after reset")

endmodule

bind code39_reflectance_decoder_unit c39rd_checker u_c39rd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_sample     (in_sample),
  .in_time_us    (in_time_us),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char_code (out_char_code),
  .out_valid_res (out_valid_res),
  .out_reversed  (out_reversed),
  .cfg_wr_en     (cfg_wr_en),
  .cfg_index     (cfg_index),
  .cfg_wdata     (cfg_wdata)
);

/* tb/code39_reflectance_decoder_unit_checker.sv */
// Checker for the Code 39 decoder: predicts each decoded character and compares result requests.
`timescale 1ns / 1ps
module code39_reflectance_decoder_unit_checker #(
  parameter int WIDTH_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [c39rd_pkg::SAMPLE_BITS-1:0]    in_sample,
  input  logic [c39rd_pkg::TIME_BITS-1:0]      in_time_us,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [c39rd_pkg::CHAR_BITS-1:0]      out_char_code,
  input  logic                                 out_valid_res,
  input  logic                                 out_reversed,
  input  logic                                 cfg_wr_en,
  input  logic [c39rd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [c39rd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output int                                   fail_count,
  output int                                   pending_count
);
  import c39rd_pkg::*;

  localparam logic [TIME_BITS-1:0] WIDTH_MAX = TIME_BITS'((64'd1 << WIDTH_BITS) - 64'd1);

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 valid_res;
    logic                 reversed;
  } decode_result_t;

  logic [THRESH_BITS-1:0] thresh_q;
  logic [GAP_BITS-1:0]    gap_q;
  logic                   in_symbol;
  logic                   bar_running;
  logic [TIME_BITS-1:0]   edge_time;
  int unsigned            elem_count;
  logic [WIDTH_BITS-1:0]  elem_width [ELEMENTS];
  decode_result_t         expected_decodes [$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic decode_result_t match_symbol();
    decode_result_t        res;
    logic [WIDTH_BITS-1:0] narrowest;
    sym_mask_t             fwd;
    sym_mask_t             rev;
    bit                    found;
    narrowest = elem_width[0];
    fwd = '0;
    rev = '0;
    found = 1'b0;
    res.char_code = INVALID_CHAR;
    res.valid_res = 1'b0;
    res.reversed = 1'b0;
    for (int i = 1; i < ELEMENTS; i++) begin
      if (elem_width[i] < narrowest) narrowest = elem_width[i];
    end
    for (int i = 0; i < ELEMENTS; i++) begin
      if (2 * longint'(elem_width[i]) > 3 * longint'(narrowest)) begin
        fwd[ELEMENTS-1-i] = 1'b1;
        rev[i] = 1'b1;
      end
    end
    for (int i = 0; i < TABLE_SIZE && !found; i++) begin
      if (fwd == SYM_MASKS[i]) begin
        res.char_code = SYM_CHARS[i];
        res.valid_res = 1'b1;
        found = 1'b1;
      end else if (rev == SYM_MASKS[i]) begin
        res.char_code = SYM_CHARS[i];
        res.valid_res = 1'b1;
        res.reversed = 1'b1;
        found = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic open_symbol(input logic [TIME_BITS-1:0] t);
    in_symbol = 1'b1;
    bar_running = 1'b1;
    elem_count = 0;
    edge_time = t;
  endtask

  task automatic take_sample(input logic [SAMPLE_BITS-1:0] s, input logic [TIME_BITS-1:0] t);
    logic                 dark;
    logic [TIME_BITS-1:0] dur;
    decode_result_t       res;
    dark = s > thresh_q;
    if (!in_symbol) begin
      if (dark) open_symbol(t);
      return;
    end
    if (dark == bar_running) return;
    dur = t - edge_time;
    if (dark && dur > gap_q) begin
      res.char_code = INVALID_CHAR;
      res.valid_res = 1'b0;
      res.reversed = 1'b0;
      expected_decodes.push_back(res);
      open_symbol(t);
      return;
    end
    if (elem_count < ELEMENTS) begin
      elem_width[elem_count] = (dur > WIDTH_MAX) ? '1 : dur[WIDTH_BITS-1:0];
      elem_count++;
    end
    bar_running = dark;
    edge_time = t;
    if (elem_count >= ELEMENTS) begin
      expected_decodes.push_back(match_symbol());
      elem_count = 0;
      in_symbol = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    decode_result_t want;
    if (!rst_n) begin
      thresh_q = THRESH_RESET;
      gap_q = GAP_RESET;
      in_symbol = 1'b0;
      bar_running = 1'b0;
      edge_time = '0;
      elem_count = 0;
      for (int i = 0; i < ELEMENTS; i++) elem_width[i] = '0;
      expected_decodes.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_BLACK_THRESHOLD: thresh_q = cfg_wdata[THRESH_BITS-1:0];
          REG_END_GAP:         gap_q = cfg_wdata[GAP_BITS-1:0];
          default: ;
        endcase
      end
      // The result side is checked first so that a request predicted at this
      // edge can never pair with a result already on its way out.
      if (out_valid && !out_stall) begin
        if (expected_decodes.size() == 0) begin
          report_mismatch($sformatf("result char %0h with none expected", out_char_code));
        end else begin
          want = expected_decodes.pop_front();
          if (out_char_code !== want.char_code)
            report_mismatch($sformatf("char_code expected %0h got %0h",
                                      want.char_code, out_char_code));
          if (out_valid_res !== want.valid_res)
            report_mismatch($sformatf("valid_res expected %0b got %0b",
                                      want.valid_res, out_valid_res));
          if (out_reversed !== want.reversed)
            report_mismatch($sformatf("reversed expected %0b got %0b",
                                      want.reversed, out_reversed));
        end
      end
      if (in_valid && !in_stall) take_sample(in_sample, in_time_us);
    end
    pending_count = expected_decodes.size();
  end

endmodule

/* tb/code39_reflectance_decoder_unit_tb.sv */
// Top of the Code 39 decoder testbench: clock, reset, sample stimulus, stalls and verdict.
`timescale 1ns / 1ps
module code39_reflectance_decoder_unit_tb;
  import c39rd_pkg::*;

  localparam int WIDTH_BITS     = 16;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [SAMPLE_BITS-1:0]    in_sample = '0;
  logic [TIME_BITS-1:0]      in_time_us = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [CHAR_BITS-1:0]      out_char_code;
  logic                      out_valid_res;
  logic                      out_reversed;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = REG_BLACK_THRESHOLD;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  int                        fail_count;
  int                        pending_count;

  logic [THRESH_BITS-1:0]    cur_thresh = THRESH_RESET;
  logic [GAP_BITS-1:0]       cur_gap = GAP_RESET;
  logic [TIME_BITS-1:0]      now_us = '0;
  int unsigned               burst_left = 0;
  int unsigned               items_sent = 0;
  int unsigned               sweep_idx = 0;
  int unsigned               idle_cycles = 0;

  int unsigned               stall_mode = 0;
  int unsigned               mode_left = 0;
  int unsigned               run_left = 0;
  int unsigned               tick = 0;
  logic                      run_level = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  code39_reflectance_decoder_unit #(.WIDTH_BITS(WIDTH_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_time_us(in_time_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char_code(out_char_code), .out_valid_res(out_valid_res),
    .out_reversed(out_reversed),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  code39_reflectance_decoder_unit_checker #(.WIDTH_BITS(WIDTH_BITS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_time_us(in_time_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char_code(out_char_code), .out_valid_res(out_valid_res),
    .out_reversed(out_reversed),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // The receiver switches between free running, coin-flip, periodic and long-run stalls.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(100, 400);
    end else begin
      mode_left--;
    end
    tick++;
    if (run_left == 0) begin
      run_level = ~run_level;
      run_left = $urandom_range(1, 12);
    end else begin
      run_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= 1'($urandom_range(0, 1));
      2:       out_stall <= (tick % 7) < 4;
      default: out_stall <= run_level;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] bar_level();
    if (cur_thresh == '1) return '1;
    return SAMPLE_BITS'($urandom_range(4095, int'(cur_thresh) + 1));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] space_level();
    return SAMPLE_BITS'($urandom_range(int'(cur_thresh), 0));
  endfunction

  function automatic logic [TIME_BITS-1:0] noise_step();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom;
      2:       return cur_gap;
      3:       return cur_gap + 1;
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s, input logic [TIME_BITS-1:0] t);
    int unsigned gap_cycles;
    if (burst_left == 0) begin
      gap_cycles = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap_cycles) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_time_us <= t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic close_element(input logic [TIME_BITS-1:0] dur, input bit bar_closes);
    now_us = now_us + dur;
    send_sample(bar_closes ? bar_level() : space_level(), now_us);
  endtask

  // Bars are the even elements; a closing request carries the opposite colour.
  task automatic send_symbol(input int unsigned idx, input bit flip, input int unsigned unit,
                             input bit extras);
    int unsigned dur;
    int unsigned mid;
    bit          wide;
    send_sample(bar_level(), now_us);
    for (int i = 0; i < ELEMENTS; i++) begin
      wide = flip ? SYM_MASKS[idx][i] : SYM_MASKS[idx][ELEMENTS-1-i];
      dur = (wide ? unit * $urandom_range(2, 3) : unit) + $urandom_range(0, unit / 10);
      if (extras && $urandom_range(0, 4) == 0) begin
        mid = $urandom_range(0, dur);
        send_sample((i % 2 == 0) ? bar_level() : space_level(), now_us + mid);
      end
      close_element(dur, i % 2 == 1);
    end
  endtask

  task automatic send_broken_symbol();
    int unsigned count;
    int unsigned unit;
    count = $urandom_range(0, 7);
    unit = $urandom_range(20, 3000);
    send_sample(bar_level(), now_us);
    for (int i = 0; i < count; i++) close_element(unit * $urandom_range(1, 3), i % 2 == 1);
    if (count % 2 == 0) close_element(unit, 1'b0);
    case ($urandom_range(0, 2))
      0:       close_element(cur_gap, 1'b1);
      1:       close_element(cur_gap + 1, 1'b1);
      default: close_element($urandom, 1'b1);
    endcase
  endtask

  task automatic random_traffic(input int unsigned target);
    int unsigned first;
    int unsigned idx;
    int unsigned unit;
    first = items_sent;
    while (items_sent - first < target) begin
      case ($urandom_range(0, 9))
        7: send_broken_symbol();
        8, 9: begin
          repeat ($urandom_range(1, 8)) begin
            now_us = now_us + noise_step();
            send_sample(SAMPLE_BITS'($urandom_range(0, 4095)), now_us);
          end
        end
        default: begin
          if (sweep_idx < TABLE_SIZE) begin
            idx = sweep_idx;
            sweep_idx++;
          end else begin
            idx = $urandom_range(0, TABLE_SIZE - 1);
          end
          unit = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(20, 3000);
          send_symbol(idx, 1'($urandom_range(0, 1)), unit, 1'b1);
          repeat ($urandom_range(0, 2)) begin
            now_us = now_us + $urandom_range(1, 5000);
            send_sample(space_level(), now_us);
          end
          now_us = now_us + $urandom_range(1, 5000);
        end
      endcase
    end
  endtask

  task automatic directed_checks();
    send_sample('0, '0);
    send_sample(THRESH_RESET, '1);
    // A reversed zero that runs across the wrap of the microsecond counter.
    now_us = 32'hFFFF_FF00;
    send_symbol(0, 1'b1, 40, 1'b0);
    // A white gap one past the limit aborts and restarts on the closing bar.
    now_us = now_us + 50;
    send_sample('1, now_us);
    close_element(100, 1'b0);
    close_element(cur_gap + 1, 1'b1);
    // A saturated first bar followed by narrow elements matches nothing.
    close_element(100000, 1'b0);
    for (int i = 1; i < ELEMENTS; i++) close_element(100, i % 2 == 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [THRESH_BITS-1:0] thr, input logic [GAP_BITS-1:0] gap);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_BLACK_THRESHOLD;
    cfg_wdata <= CFG_DATA_BITS'(thr);
    @(negedge clk);
    cfg_index <= REG_END_GAP;
    cfg_wdata <= gap;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_thresh = thr;
    cur_gap = gap;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_checks();
    random_traffic(300);
    drain();
    set_config('1, '1);
    random_traffic(30);
    drain();
    set_config('0, '0);
    random_traffic(150);
    drain();
    set_config(THRESH_BITS'($urandom_range(1, 4094)), $urandom_range(20000, 2000000));
    random_traffic(300);
    drain();
    set_config(THRESH_BITS'($urandom_range(1500, 2800)), '1);
    random_traffic(650);
    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* code39_reflectance_decoder_unit.f */
+incdir+rtl
rtl/c39rd_pkg.sv
rtl/code39_reflectance_decoder_unit.sv
rtl/c39rd_checker.sv
tb/code39_reflectance_decoder_unit_checker.sv
tb/code39_reflectance_decoder_unit_tb.sv
